// ----- hw/rtl/ipv6p_pkg.sv -----
package ipv6p_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned GroupW  = 16;
  localparam int unsigned NumGrp  = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned BucketW = 8;
  localparam int unsigned OutDataW = 2 * HalfW + BucketW;

  localparam logic [ChW-1:0] ChColon = 8'h3A;

  typedef logic [NumGrp-1:0][GroupW-1:0] grp_arr_t;

  // snapshot of one finished line, handed to the expansion stage
  typedef struct packed {
    logic            pre_ok;
    logic            gap_seen;
    logic [CountW-1:0] gap_pos;
    logic [CountW-1:0] count;
    grp_arr_t        groups;
  } snap_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic is_ws(input logic [ChW-1:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      8'h20, [8'h09:8'h0D]: r = 1'b1;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic hex_t hex_decode(input logic [ChW-1:0] c);
    hex_t r;
    r = '0;
    case (c) inside
      [8'h30:8'h39]: r = '{valid: 1'b1, value: c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = '{valid: 1'b1, value: 4'(c[2:0] + 3'd1) + 4'd8};
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/ipv6p_char_fsm.sv -----
module ipv6p_char_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ipv6p_pkg::ChW-1:0]    ch_i,
  input  logic                         line_end_i,
  output logic                         snap_valid_o,
  input  logic                         snap_ready_i,
  output ipv6p_pkg::snap_t             snap_o
);
  import ipv6p_pkg::*;

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_FIRST = 5'b00010,
    PH_FIELD = 5'b00100,
    PH_COLON = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  grp_arr_t          groups_q, groups_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] gap_pos_q, gap_pos_d;
  logic              gap_seen_q, gap_seen_d;
  logic [GroupW-1:0] accum_q, accum_d;
  logic              have_digit_q, have_digit_d;
  phase_e            phase_q, phase_d;
  logic              bad_q, bad_d;

  logic  snap_valid_q;
  snap_t snap_q, snap_d;
  logic  accept;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic do_field;
    logic is_colon;
    hex_t hx;
    do_field     = 1'b0;
    is_colon     = (ch_i == ChColon);
    hx           = hex_decode(ch_i);
    groups_d     = groups_q;
    cnt_d        = cnt_q;
    gap_pos_d    = gap_pos_q;
    gap_seen_d   = gap_seen_q;
    accum_d      = accum_q;
    have_digit_d = have_digit_q;
    phase_d      = phase_q;
    bad_d        = bad_q;

    if (!bad_q) begin
      case (phase_q)
        PH_LEAD: begin
          if (is_ws(ch_i)) begin
            phase_d = PH_LEAD;
          end else if (is_colon) begin
            phase_d = PH_FIRST;
          end else begin
            phase_d  = PH_FIELD;
            do_field = 1'b1;
          end
        end
        PH_FIRST: begin
          if (is_colon) begin
            gap_seen_d = 1'b1;
            gap_pos_d  = '0;
            phase_d    = PH_FIELD;
          end else begin
            bad_d = 1'b1;
          end
        end
        PH_COLON: begin
          if (is_colon) begin
            if (gap_seen_q) begin
              bad_d = 1'b1;
            end else begin
              gap_seen_d = 1'b1;
              gap_pos_d  = cnt_q;
              phase_d    = cnt_q[3] ? PH_DONE : PH_FIELD;
            end
          end else if (cnt_q[3]) begin
            phase_d = PH_DONE;
          end else begin
            phase_d  = PH_FIELD;
            do_field = 1'b1;
          end
        end
        PH_FIELD: do_field = 1'b1;
        default:  phase_d = phase_q;
      endcase
    end

    if (do_field) begin
      if (hx.valid) begin
        accum_d      = {accum_q[GroupW-5:0], hx.value};
        have_digit_d = 1'b1;
      end else begin
        if (have_digit_d) begin
          if (!cnt_d[3]) begin
            groups_d[cnt_d[2:0]] = accum_d;
            cnt_d = cnt_d + 4'd1;
          end
          accum_d      = '0;
          have_digit_d = 1'b0;
        end
        if (is_ws(ch_i))   phase_d = PH_DONE;
        else if (is_colon) phase_d = PH_COLON;
        else               bad_d   = 1'b1;
      end
    end

    // close the open group on the last character
    if (line_end_i && !bad_d && phase_d == PH_FIELD && have_digit_d && !cnt_d[3]) begin
      groups_d[cnt_d[2:0]] = accum_d;
      cnt_d = cnt_d + 4'd1;
    end

    snap_d.pre_ok   = !bad_d && (phase_d != PH_LEAD) && (phase_d != PH_FIRST);
    snap_d.gap_seen = gap_seen_d;
    snap_d.gap_pos  = gap_pos_d;
    snap_d.count    = cnt_d;
    snap_d.groups   = groups_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      gap_pos_q    <= '0;
      gap_seen_q   <= 1'b0;
      accum_q      <= '0;
      have_digit_q <= 1'b0;
      phase_q      <= PH_LEAD;
      bad_q        <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (line_end_i) begin
          cnt_q        <= '0;
          gap_pos_q    <= '0;
          gap_seen_q   <= 1'b0;
          accum_q      <= '0;
          have_digit_q <= 1'b0;
          phase_q      <= PH_LEAD;
          bad_q        <= 1'b0;
        end else begin
          cnt_q        <= cnt_d;
          gap_pos_q    <= gap_pos_d;
          gap_seen_q   <= gap_seen_d;
          accum_q      <= accum_d;
          have_digit_q <= have_digit_d;
          phase_q      <= phase_d;
          bad_q        <= bad_d;
        end
      end
      if (accept && line_end_i) snap_valid_q <= 1'b1;
      else if (snap_ready_i)    snap_valid_q <= 1'b0;
    end
  end

  // group storage is only read below the group count, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) groups_q <= groups_d;
    if (accept && line_end_i) snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("group count above eight");

  a_gap_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_pos_q <= cnt_q)
    else $error("gap position beyond group count");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !snap_ready_i |=> snap_valid_q && $stable(snap_q))
    else $error("pending line snapshot changed while stalled");

endmodule

// ----- hw/rtl/ipv6p_expand.sv -----
module ipv6p_expand (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              snap_valid_i,
  output logic                              snap_ready_o,
  input  ipv6p_pkg::snap_t                  snap_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ok_o,
  output logic [ipv6p_pkg::HalfW-1:0]       addr_high_o,
  output logic [ipv6p_pkg::HalfW-1:0]       addr_low_o,
  output logic [ipv6p_pkg::BucketW-1:0]     bucket_o
);
  import ipv6p_pkg::*;

  logic              out_valid_q;
  logic              ok_q, ok_d;
  logic [HalfW-1:0]  high_q, high_d, low_q, low_d;
  grp_arr_t          full;
  logic [CountW-1:0] tail_start;

  assign snap_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    tail_start = 4'd8 - snap_i.count + snap_i.gap_pos;
    if (snap_i.gap_seen) begin
      ok_d = snap_i.pre_ok && !snap_i.count[3] && (snap_i.gap_pos <= snap_i.count);
    end else begin
      ok_d = snap_i.pre_ok && (snap_i.count == 4'd8);
    end
    // groups after the gap move to the last group positions, the low end of the address
    for (int p = 0; p < NumGrp; p++) begin
      if (!snap_i.gap_seen || 4'(p) < snap_i.gap_pos) begin
        full[p] = snap_i.groups[p];
      end else if (4'(p) >= tail_start) begin
        full[p] = snap_i.groups[3'(p) + snap_i.count[2:0]];
      end else begin
        full[p] = '0;
      end
    end
    high_d = ok_d ? {full[0], full[1], full[2], full[3]} : '0;
    low_d  = ok_d ? {full[4], full[5], full[6], full[7]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      ok_q   <= ok_d;
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign addr_high_o = high_q;
  assign addr_low_o  = low_q;
  assign bucket_o    = high_q[HalfW-1 -: BucketW];

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ok_q |-> high_q == '0 && low_q == '0)
    else $error("rejected line carries a nonzero address");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(high_q) && $stable(low_q)
      && $stable(ok_q))
    else $error("result register changed while stalled");

  a_full_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i && snap_i.gap_seen && snap_i.count == 4'd8 |-> !ok_d)
    else $error("eight groups with a gap accepted");

endmodule

// ----- hw/rtl/ipv6_text_address_parser_top.sv -----
// path: a line's snapshot is registered on the edge that takes its last character beat, then its result is registered
// throughput: one character beat per cycle; a result held downstream stalls the input only
//   once the next finished line also waits in the snapshot register
// the line state updates on each accepted character beat; the gap expansion runs in the following register stage
// reset: rst_ni clears the line state and both valid flags, no result is pending after reset
module ipv6_text_address_parser_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ipv6p_pkg::ChW-1:0]          s_axis_tdata,   // [7:0] ch
  input  logic                               s_axis_tlast,   // line_end
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ipv6p_pkg::OutDataW-1:0]     m_axis_tdata,   // [63:0] addr_high,
                                                             // [127:64] addr_low,
                                                             // [135:128] bucket
  output logic                               m_axis_tuser    // [0] ok
);
  import ipv6p_pkg::*;

  logic         snap_valid, snap_ready;
  snap_t        snap;
  logic [HalfW-1:0]   addr_high, addr_low;
  logic [BucketW-1:0] bucket;

  ipv6p_char_fsm u_char_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .ch_i         (s_axis_tdata),
    .line_end_i   (s_axis_tlast),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  ipv6p_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .ok_o         (m_axis_tuser),
    .addr_high_o  (addr_high),
    .addr_low_o   (addr_low),
    .bucket_o     (bucket)
  );

  assign m_axis_tdata = {bucket, addr_low, addr_high};

endmodule
